@@ rtl/plz_pkg.sv @@
// Shared types, constants and sizes for the PalmDOC LZ77 decompressor.
package plz_pkg;

  localparam int WINDOW_DEPTH = 2048;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int PROD_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int DIST_W       = 11;
  localparam int LEN_W        = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] PAIR_LO      = 8'h80;
  localparam logic [7:0] PAIR_HI      = 8'hBF;
  localparam logic [7:0] SPACE_LO     = 8'hC0;
  localparam logic [7:0] RUN_LO       = 8'h01;
  localparam logic [7:0] RUN_HI       = 8'h08;
  localparam logic [7:0] SPACE_TOGGLE = 8'h80;
  localparam logic [LEN_W-1:0] LEN_BIAS = 4'd3;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LIT,
    MODE_PAIR
  } tok_mode_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_SPC,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [DIST_W-1:0] copy_dist;
    logic [LEN_W-1:0]  len;
    logic              bad;
    logic              trunc;
    logic              rec_end;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DATA,
    BK_TRUNC
  } back_state_t;

endpackage

@@ rtl/plz_in_if.sv @@
// Compressed byte channel: valid/ready with byte and record-end mark.
interface plz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       record_end;

  modport source (output valid, output in_byte, output record_end, input ready);
  modport sink   (input valid, input in_byte, input record_end, output ready);
endinterface

@@ rtl/plz_out_if.sv @@
// Decompressed byte channel: valid/ready with byte and status flags.
interface plz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       error;
  logic       record_done;

  modport source (output valid, output out_byte, output run_last, output error,
                  output record_done, input ready);
  modport sink   (input valid, input out_byte, input run_last, input error,
                  input record_done, output ready);
endinterface

@@ rtl/plz_queue.sv @@
// Small command FIFO between the token parser and the output engine.
module plz_queue
  import plz_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/plz_front.sv @@
// Token parser: accepts compressed bytes and queues output commands.
module plz_front
  import plz_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  plz_in_if.sink din,
  output logic   push,
  output cmd_t   cmd,
  input  logic   full
);

  tok_mode_t         mode;
  tok_mode_t         mode_next;
  logic [3:0]        literals_left;
  logic [3:0]        literals_left_next;
  logic [7:0]        pair_first_byte;
  logic [7:0]        pair_first_byte_next;
  logic [PROD_W-1:0] produced_count;
  logic [PROD_W-1:0] produced_count_next;
  logic [LEN_W-1:0]  nbytes;
  logic [PROD_W:0]   prod_sum;
  logic              accept;
  logic [7:0]        b;
  logic [DIST_W-1:0] copy_dist;
  logic [LEN_W-1:0]  len;

  assign din.ready = !full;
  assign accept    = din.valid && !full;
  assign b         = din.in_byte;
  assign copy_dist = {pair_first_byte[5:0], b[7:3]};
  assign len       = LEN_W'({1'b0, b[2:0]}) + LEN_BIAS;

  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_LIT: begin
        if (literals_left <= 4'd1) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_PAIR: mode_next = MODE_IDLE;
      default: begin
        if (b >= PAIR_LO && b <= PAIR_HI) begin
          mode_next = MODE_PAIR;
        end else if (b >= RUN_LO && b <= RUN_HI) begin
          mode_next = MODE_LIT;
        end
      end
    endcase
  end

  always_comb begin
    cmd                  = '0;
    cmd.kind             = CMD_NONE;
    cmd.data             = b;
    cmd.copy_dist        = copy_dist;
    cmd.len              = len;
    cmd.rec_end          = din.record_end;
    nbytes               = '0;
    literals_left_next   = literals_left;
    pair_first_byte_next = pair_first_byte;
    unique case (mode)
      MODE_LIT: begin
        cmd.kind = CMD_LIT;
        nbytes   = 4'd1;
        if (literals_left > 4'd0) begin
          literals_left_next = literals_left - 4'd1;
        end
      end
      MODE_PAIR: begin
        cmd.kind             = CMD_COPY;
        cmd.bad              = (copy_dist == '0) || (PROD_W'(copy_dist) > produced_count);
        nbytes               = len;
        pair_first_byte_next = '0;
      end
      default: begin
        if (b >= PAIR_LO && b <= PAIR_HI) begin
          pair_first_byte_next = b;
        end else if (b >= SPACE_LO) begin
          cmd.kind = CMD_SPC;
          nbytes   = 4'd2;
        end else if (b >= RUN_LO && b <= RUN_HI) begin
          literals_left_next = b[3:0];
        end else begin
          cmd.kind = CMD_LIT;
          nbytes   = 4'd1;
        end
      end
    endcase
    cmd.trunc = din.record_end && (mode_next != MODE_IDLE);
    push      = accept && ((cmd.kind != CMD_NONE) || cmd.trunc);
  end

  always_comb begin
    prod_sum = {1'b0, produced_count} + (PROD_W+1)'(nbytes);
    if (prod_sum > (PROD_W+1)'(WINDOW_DEPTH)) begin
      produced_count_next = PROD_W'(WINDOW_DEPTH);
    end else begin
      produced_count_next = prod_sum[PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      literals_left   <= '0;
      pair_first_byte <= '0;
      produced_count  <= '0;
    end else if (accept) begin
      if (din.record_end) begin
        mode            <= MODE_IDLE;
        literals_left   <= '0;
        pair_first_byte <= '0;
        produced_count  <= '0;
      end else begin
        mode            <= mode_next;
        literals_left   <= literals_left_next;
        pair_first_byte <= pair_first_byte_next;
        produced_count  <= produced_count_next;
      end
    end
  end

endmodule

@@ rtl/plz_back.sv @@
// Output engine: runs queued commands against the history window.
module plz_back
  import plz_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      empty,
  output logic      pop,
  plz_out_if.source dout
);

  back_state_t        state;
  back_state_t        state_next;
  cmd_t               cur;
  logic [LEN_W-1:0]   cnt;
  logic [LEN_W-1:0]   init_cnt;
  logic [HIST_AW-1:0] wp;
  logic [HIST_AW-1:0] rd_addr;
  logic [HIST_AW:0]   diff;
  logic [7:0]         rd_data;
  logic [7:0]         hist [WINDOW_DEPTH];

  logic               out_valid;
  logic [7:0]         out_byte;
  logic               run_last;
  logic               error;
  logic               record_done;

  logic               emit_ok;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_err;
  logic               last_byte;
  logic               final_res;
  logic               rd_en;
  logic               hist_we;

  assign dout.valid       = out_valid;
  assign dout.out_byte    = out_byte;
  assign dout.run_last    = run_last;
  assign dout.error       = error;
  assign dout.record_done = record_done;

  assign emit_ok   = !out_valid || dout.ready;
  assign last_byte = (cur.kind == CMD_LIT) || (cnt == LEN_W'(1));
  assign hist_we   = emit && (state != BK_TRUNC);

  assign diff    = {1'b0, wp} - (HIST_AW+1)'(cur.copy_dist);
  assign rd_addr = diff[HIST_AW] ? HIST_AW'(diff + (HIST_AW+1)'(WINDOW_DEPTH))
                                 : diff[HIST_AW-1:0];

  always_comb begin
    case (head.kind)
      CMD_SPC:  init_cnt = LEN_W'(2);
      CMD_COPY: init_cnt = head.len;
      default:  init_cnt = LEN_W'(1);
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          state_next = (head.kind == CMD_NONE) ? BK_TRUNC : BK_RUN;
        end
      end
      BK_RUN: begin
        if (cur.kind == CMD_COPY && !cur.bad) begin
          state_next = BK_DATA;
        end else if (emit_ok && last_byte) begin
          state_next = cur.trunc ? BK_TRUNC : BK_IDLE;
        end
      end
      BK_DATA: begin
        if (emit_ok) begin
          if (last_byte) begin
            state_next = cur.trunc ? BK_TRUNC : BK_IDLE;
          end else begin
            state_next = BK_RUN;
          end
        end
      end
      BK_TRUNC: begin
        if (emit_ok) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_byte = '0;
    emit_err  = 1'b0;
    final_res = last_byte && !cur.trunc;
    rd_en     = 1'b0;
    unique case (state)
      BK_IDLE: pop = !empty;
      BK_RUN: begin
        case (cur.kind)
          CMD_LIT: begin
            emit      = emit_ok;
            emit_byte = cur.data;
          end
          CMD_SPC: begin
            emit      = emit_ok;
            emit_byte = (cnt == LEN_W'(2)) ? BYTE_SPACE : (cur.data ^ SPACE_TOGGLE);
          end
          CMD_COPY: begin
            if (cur.bad) begin
              emit     = emit_ok;
              emit_err = 1'b1;
            end else begin
              rd_en = 1'b1;
            end
          end
          default: emit = 1'b0;
        endcase
      end
      BK_DATA: begin
        emit      = emit_ok;
        emit_byte = rd_data;
      end
      BK_TRUNC: begin
        emit      = emit_ok;
        emit_err  = 1'b1;
        final_res = 1'b1;
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      wp        <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      if (hist_we) begin
        wp <= (wp == HIST_AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      cnt <= init_cnt;
    end else if (hist_we) begin
      cnt <= cnt - LEN_W'(1);
    end
    if (emit) begin
      out_byte    <= emit_byte;
      error       <= emit_err;
      run_last    <= final_res;
      record_done <= final_res && cur.rec_end;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[wp] <= emit_byte;
    end
    if (rd_en) begin
      rd_data <= hist[rd_addr];
    end
  end

endmodule

@@ rtl/palmdoc_lz77_decompressor_core.sv @@
// Top level of the PalmDOC LZ77 decompressor: parser, command queue, output engine.
// A good copy pair reads each byte from the history window, then emits it and writes it back;
// a bad copy emits one error byte per length, and a truncation adds one error result.
// The parser takes a byte each cycle until the four-entry command queue fills.
// Synchronous reset clears control state; history contents stay undefined until written.
module palmdoc_lz77_decompressor_core
  import plz_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  plz_in_if.sink    din,
  plz_out_if.source dout
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic full;
  logic empty;

  plz_front u_front (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .push (push),
    .cmd  (push_cmd),
    .full (full)
  );

  plz_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  plz_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .dout  (dout)
  );

endmodule

@@ rtl/plz_checker.sv @@
// Port-level checks for the decompressor, bound to the top level.
module plz_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       error,
  input logic       record_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(error)
      && $stable(run_last) && $stable(record_done))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> out_byte == 8'h00)
    else $error("error result with nonzero byte");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_done |-> run_last)
    else $error("record end without last-of-run flag");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind palmdoc_lz77_decompressor_core plz_checker u_plz_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .out_byte    (dout.out_byte),
  .run_last    (dout.run_last),
  .error       (dout.error),
  .record_done (dout.record_done)
);

@@ tb/tb_palmdoc_lz77_decompressor_core.sv @@
// Testbench for palmdoc_lz77_decompressor_core: directed and random records checked per output byte.
`timescale 1ns / 100ps

module tb_palmdoc_lz77_decompressor_core;
  import plz_pkg::*;

  localparam int DIST_MAX = (1 << DIST_W) - 1;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       error;
    logic       record_done;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;

  plz_in_if  din_if ();
  plz_out_if dout_if ();

  palmdoc_lz77_decompressor_core DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always #10 clk = ~clk;

  // decoder state mirrored from the compressed stream
  logic [7:0]         win_mem [WINDOW_DEPTH];
  logic [HIST_AW-1:0] win_wr;
  logic [PROD_W-1:0]  rec_count;
  tok_mode_t          dec_mode;
  logic [3:0]         run_left;
  logic [7:0]         pair_lead;
  out_beat_t          step_out [11];
  int                 step_n;

  out_beat_t due_bytes [$];

  int fail_count = 0;
  int bytes_in = 0;
  int records_in = 0;
  int bytes_out = 0;
  int errors_out = 0;

  function automatic void put_byte(input logic [7:0] v, input logic err);
    step_out[step_n] = '{data: err ? 8'h00 : v, run_last: 1'b0, error: err, record_done: 1'b0};
    step_n++;
    win_mem[win_wr] = err ? 8'h00 : v;
    win_wr++;
    if (rec_count < WINDOW_DEPTH) rec_count++;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [DIST_W-1:0]  copy_dist;
    logic [HIST_AW-1:0] rd;
    logic               bad;
    int                 span;
    step_n = 0;
    case (dec_mode)
      MODE_LIT: begin
        put_byte(b, 1'b0);
        if (run_left != 0) run_left--;
        if (run_left == 0) dec_mode = MODE_IDLE;
      end
      MODE_PAIR: begin
        copy_dist = {pair_lead[5:0], b[7:3]};
        span = int'(b[2:0]) + int'(LEN_BIAS);
        bad = (copy_dist == 0) || (copy_dist > rec_count);
        for (int i = 0; i < span; i++) begin
          rd = win_wr - copy_dist;
          put_byte(bad ? 8'h00 : win_mem[rd], bad);
        end
        dec_mode = MODE_IDLE;
        pair_lead = 8'h00;
      end
      default: begin
        if (b >= PAIR_LO && b <= PAIR_HI) begin
          pair_lead = b;
          dec_mode = MODE_PAIR;
        end else if (b >= SPACE_LO) begin
          put_byte(BYTE_SPACE, 1'b0);
          put_byte(b ^ SPACE_TOGGLE, 1'b0);
        end else if (b >= RUN_LO && b <= RUN_HI) begin
          run_left = b[3:0];
          dec_mode = MODE_LIT;
        end else begin
          put_byte(b, 1'b0);
        end
      end
    endcase
    if (last) begin
      // token still open at record end: one truncation marker
      if (dec_mode != MODE_IDLE) begin
        step_out[step_n] = '{data: 8'h00, run_last: 1'b0, error: 1'b1, record_done: 1'b0};
        step_n++;
      end
      rec_count = '0;
      dec_mode = MODE_IDLE;
      run_left = '0;
      pair_lead = 8'h00;
      if (step_n > 0) step_out[step_n-1].record_done = 1'b1;
    end
    if (step_n > 0) step_out[step_n-1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) due_bytes.push_back(step_out[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 17) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid      <= 1'b1;
    din_if.in_byte    <= b;
    din_if.record_end <= last;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    decode_byte(b, last);
    bytes_in++;
    if (last) records_in++;
  endtask

  task automatic wait_drained();
    din_if.valid <= 1'b0;
    do @(posedge clk); while (due_bytes.size() != 0);
  endtask

  function automatic logic [DIST_W-1:0] pick_dist(input logic good);
    int hi;
    hi = (rec_count > DIST_MAX) ? DIST_MAX : int'(rec_count);
    if (good && hi > 0) begin
      if ($urandom_range(3) == 0) return DIST_W'($urandom_range(hi, 1));
      return DIST_W'($urandom_range(hi < 16 ? hi : 16, 1));
    end
    if (hi < DIST_MAX && $urandom_range(1) == 1) return DIST_W'($urandom_range(DIST_MAX, hi + 1));
    return '0;
  endfunction

  task automatic send_pair(input logic [DIST_W-1:0] copy_dist, input logic [2:0] len_code,
                           input logic last);
    send_byte(PAIR_LO | {2'b00, copy_dist[10:5]}, 1'b0);
    send_byte({copy_dist[4:0], len_code}, last);
  endtask

  task automatic send_run(input int n, input int keep, input logic last);
    send_byte(8'(n), last && keep == 0);
    for (int i = 0; i < keep; i++) send_byte(8'($urandom_range(255)), last && i == keep - 1);
  endtask

  function automatic logic [7:0] rand_literal();
    if ($urandom_range(9) == 0) return 8'h00;
    return 8'($urandom_range(8'h7F, RUN_HI + 1));
  endfunction

  task automatic test_token_classes();
    logic [7:0] seq [24];
    seq = '{8'h00, 8'h7F, 8'h09,
            RUN_HI, 8'h00, 8'hFF, PAIR_LO, PAIR_HI, SPACE_LO, RUN_LO, RUN_HI, 8'h7F,
            SPACE_LO, 8'hFF,
            PAIR_LO, 8'h0F,   // distance 1, length 10: overlapping copy
            PAIR_LO, 8'h00,   // distance 0
            PAIR_LO, 8'hE0,   // distance equal to bytes produced so far
            8'h81, 8'h07,     // distance one past bytes produced
            RUN_LO, 8'h55};
    foreach (seq[i]) send_byte(seq[i], i == 23);
  endtask

  task automatic test_record_edges();
    send_byte(RUN_LO + 8'd4, 1'b1);
    send_byte(8'hA0, 1'b1);
    send_byte(RUN_LO + 8'd1, 1'b0);
    send_byte(8'h61, 1'b1);
    send_pair(11'd1, 3'd0, 1'b1);   // history exists but record is fresh
    send_byte(SPACE_LO + 8'd1, 1'b1);
  endtask

  task automatic test_mixed_records();
    int stop_at;
    int tokens;
    int pick;
    int n;
    logic fin;
    stop_at = bytes_in + 30;
    while (bytes_in < stop_at) begin
      tokens = $urandom_range(10, 1);
      for (int t = 0; t < tokens; t++) begin
        fin = (t == tokens - 1);
        pick = $urandom_range(99);
        n = $urandom_range(RUN_HI, RUN_LO);
        if (fin && pick < 12) begin
          case ($urandom_range(2))
            0: send_run(n, $urandom_range(n - 1, 0), 1'b1);
            1: send_byte(8'($urandom_range(PAIR_HI, PAIR_LO)), 1'b1);
            default: send_byte(8'($urandom_range(255)), 1'b1);
          endcase
        end else if (pick < 30) begin
          send_byte(rand_literal(), fin);
        end else if (pick < 45) begin
          send_run(n, n, fin);
        end else if (pick < 58) begin
          send_byte(8'($urandom_range(255, SPACE_LO)), fin);
        end else if (pick < 90) begin
          send_pair(pick_dist(1'b1), 3'($urandom_range(7)), fin);
        end else if (pick < 95) begin
          send_pair(pick_dist(1'b0), 3'($urandom_range(7)), fin);
        end else begin
          send_byte(8'($urandom_range(255)), fin);
        end
      end
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  task automatic test_full_window();
    steady = 1'b1;
    for (int i = 0; i < 12; i++) send_byte(rand_literal(), 1'b0);
    while (rec_count < WINDOW_DEPTH) begin
      if (rec_count > 1000) steady = 1'b0;
      send_pair(pick_dist(1'b1), 3'd7, 1'b0);
    end
    send_pair(DIST_W'(DIST_MAX), 3'd7, 1'b0);
    send_pair(DIST_W'(DIST_MAX), 3'd0, 1'b0);
    send_pair(DIST_W'(DIST_MAX - 1), 3'd3, 1'b0);
    send_pair(DIST_W'(DIST_MAX), 3'd7, 1'b1);
  endtask

  function automatic void check_field(input string what, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    end
  endfunction

  // output side: random back-pressure and per-transfer checking
  initial begin
    out_beat_t want;
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && dout_if.valid && dout_if.ready) begin
        if (due_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transfer, expected none, actual byte %0h err %0b",
                   $time, dout_if.out_byte, dout_if.error);
        end else begin
          want = due_bytes.pop_front();
          bytes_out++;
          if (want.error) errors_out++;
          check_field("out_byte", want.data, dout_if.out_byte);
          check_field("run_last", 8'(want.run_last), 8'(dout_if.run_last));
          check_field("error", 8'(want.error), 8'(dout_if.error));
          check_field("record_done", 8'(want.record_done), 8'(dout_if.record_done));
        end
      end
      dout_if.ready <= !rst && (steady || $urandom_range(99) >= 17);
    end
  end

  initial begin
    din_if.valid      <= 1'b0;
    din_if.in_byte    <= 8'h00;
    din_if.record_end <= 1'b0;
    win_wr    = '0;
    rec_count = '0;
    dec_mode  = MODE_IDLE;
    run_left  = '0;
    pair_lead = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_token_classes();
    wait_drained();
    test_record_edges();
    wait_drained();
    test_mixed_records();
    wait_drained();
    test_full_window();
    wait_drained();
    repeat (40) @(posedge clk);
    if (due_bytes.size() != 0) fail_count++;
    $display("Sent %0d compressed bytes in %0d records; checked %0d output bytes, %0d errors.",
             bytes_in, records_in, bytes_out, errors_out);
    $display("Covered all token classes, truncations, bad distances and a full-window record.");
    if (fail_count == 0) begin
      $display("** palmdoc_lz77_decompressor_core: PASSED **");
    end else begin
      $display("** palmdoc_lz77_decompressor_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d output bytes outstanding", due_bytes.size());
    $display("** palmdoc_lz77_decompressor_core: FAILED **");
    $finish;
  end

endmodule

@@ palmdoc_lz77_decompressor_core.f @@
rtl/plz_pkg.sv
rtl/plz_in_if.sv
rtl/plz_out_if.sv
rtl/plz_queue.sv
rtl/plz_front.sv
rtl/plz_back.sv
rtl/palmdoc_lz77_decompressor_core.sv
rtl/plz_checker.sv
tb/tb_palmdoc_lz77_decompressor_core.sv
